// ===== sv/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix expression evaluator package
// Shared types and constants: operator codes, status codes, character codes.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOVALUE  = 2'd1;
    localparam logic [1:0] ST_BADCHAR  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Request to the shared arithmetic unit.
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    // Response from the shared arithmetic unit.
    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

// ===== sv/pee_alu.sv =====
// ----------------------------------------------------------------------------
// Prefix expression evaluator arithmetic unit
// Add, subtract and multiply are computed at launch and registered; signed division runs one
// quotient bit per cycle with a restoring shift-subtract loop.
// ----------------------------------------------------------------------------
module pee_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pee_pkg::alu_req_t       req,
    input  logic [VALUE_WIDTH-1:0]  lhs,
    input  logic [VALUE_WIDTH-1:0]  rhs,
    output pee_pkg::alu_rsp_t       rsp,
    output logic [VALUE_WIDTH-1:0]  result
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                   done_reg, done_next;
    logic                   dz_reg, dz_next;
    logic [VALUE_WIDTH-1:0] abs_l, abs_r;
    logic [VALUE_WIDTH:0]   trial;

    assign abs_l = lhs[VALUE_WIDTH-1] ? (~lhs + 1'b1) : lhs;
    assign abs_r = rhs[VALUE_WIDTH-1] ? (~rhs + 1'b1) : rhs;
    assign trial = {rem_reg[VALUE_WIDTH-1:0], quo_reg[VALUE_WIDTH-1]};

    // Operation launch and one division step per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        dz_next   = 1'b0;
        if (req.start)
        begin
            case (req.op)
                pee_pkg::OP_ADD:
                begin
                    res_next  = lhs + rhs;
                    done_next = 1'b1;
                end
                pee_pkg::OP_SUB:
                begin
                    res_next  = lhs - rhs;
                    done_next = 1'b1;
                end
                pee_pkg::OP_MUL:
                begin
                    res_next  = VALUE_WIDTH'(lhs * rhs);
                    done_next = 1'b1;
                end
                default:
                begin
                    if (rhs == '0)
                    begin
                        dz_next   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        cnt_next  = CW'(VALUE_WIDTH);
                        quo_next  = abs_l;
                        rem_next  = '0;
                        dvs_next  = abs_r;
                        neg_next  = lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
                    end
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (~quo_next + 1'b1) : quo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dz_reg   <= dz_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

// ===== sv/prefix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// Prefix expression evaluator
// Evaluates a prefix expression of single digits and + - * / one character
// per input beat, with a frame stack in place of a parse tree.
// ----------------------------------------------------------------------------
// Usage: the input channel (symbol, last) carries one character per beat.
// Whitespace is skipped. The output channel (value, status) carries one beat
// for each input beat with last set. Status 0 is ok, 1 no value, 2 bad
// character, 3 stack overflow; value is zero unless status is 0.
// Flow: the block takes one character at a time and holds stall high
// while it works. A skipped or pushing character goes straight to the end
// state. A digit reads the top frame from the frame memory (registered
// read); it completes the expression when the stack is empty, fills the
// left value of a frame that has none, and otherwise pops the frame
// through the shared arithmetic unit (add, subtract, multiply or divide)
// and goes on with its result. A divide by zero ends the walk. A
// character with last set then goes to the output register. A result
// waits there while the receiver stalls; the block takes no new
// character until it is taken. Reset empties the stack and clears the
// sticky status; the frame memory needs no clearing.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator #(
    parameter int STACK_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic [1:0]  status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int FW = VALUE_WIDTH + 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TOP  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [PW-1:0]          sp_reg, sp_next;
    logic                   complete_reg, complete_next;
    logic [1:0]             sticky_reg, sticky_next;
    logic [VALUE_WIDTH-1:0] final_reg, final_next;
    logic [VALUE_WIDTH-1:0] opnd_reg, opnd_next;
    logic                   last_reg, last_next;
    logic [31:0]            value_reg, value_next;
    logic [1:0]             status_reg, status_next;

    // Frame memory: {operator, has_left, left value}.
    logic [FW-1:0]          frame_mem [STACK_DEPTH];
    logic [FW-1:0]          rd_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [FW-1:0]          wr_data;
    logic [AW-1:0]          rd_addr;

    pee_pkg::alu_req_t      req;
    pee_pkg::alu_rsp_t      rsp;
    logic [VALUE_WIDTH-1:0] alu_res;

    logic                   in_take;
    logic                   is_space, is_digit, is_op;
    logic [1:0]             op_code;
    logic [AW-1:0]          top;

    pee_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .lhs    (rd_reg[VALUE_WIDTH-1:0]),
        .rhs    (opnd_reg),
        .rsp    (rsp),
        .result (alu_res)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign value     = value_reg;
    assign status    = status_reg;
    assign top       = AW'(sp_reg - 1'b1);
    assign rd_addr   = top;

    // Character classes.
    always_comb
    begin
        is_space = (symbol == pee_pkg::CH_SPACE) ||
                   (symbol >= pee_pkg::CH_TAB && symbol <= pee_pkg::CH_CR);
        is_digit = (symbol >= pee_pkg::CH_ZERO && symbol <= pee_pkg::CH_NINE);
        is_op    = 1'b1;
        case (symbol)
            pee_pkg::CH_PLUS:  op_code = pee_pkg::OP_ADD;
            pee_pkg::CH_MINUS: op_code = pee_pkg::OP_SUB;
            pee_pkg::CH_STAR:  op_code = pee_pkg::OP_MUL;
            pee_pkg::CH_SLASH: op_code = pee_pkg::OP_DIV;
            default:
            begin
                op_code = pee_pkg::OP_ADD;
                is_op   = 1'b0;
            end
        endcase
    end

    // Sequencer: parse a character, then walk the stack one frame at a time.
    always_comb
    begin
        state_next    = state_reg;
        sp_next       = sp_reg;
        complete_next = complete_reg;
        sticky_next   = sticky_reg;
        final_next    = final_reg;
        opnd_next     = opnd_reg;
        last_next     = last_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = top;
        wr_data       = '0;
        req.start     = 1'b0;
        req.op        = rd_reg[FW-1:FW-2];
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    last_next  = last;
                    state_next = S_END;
                    if (!complete_reg && sticky_reg == pee_pkg::ST_OK && !is_space)
                    begin
                        if (is_digit)
                        begin
                            opnd_next  = VALUE_WIDTH'(symbol - pee_pkg::CH_ZERO);
                            state_next = S_READ;
                        end
                        else if (is_op)
                        begin
                            if (sp_reg >= PW'(STACK_DEPTH))
                                sticky_next = pee_pkg::ST_OVERFLOW;
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(sp_reg);
                                wr_data = {op_code, 1'b0, {VALUE_WIDTH{1'b0}}};
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        else
                            sticky_next = pee_pkg::ST_BADCHAR;
                    end
                end
            end
            S_READ:
            begin
                // Operand pending; memory read of top frame issued here.
                if (sp_reg == '0)
                begin
                    complete_next = 1'b1;
                    final_next    = opnd_reg;
                    state_next    = S_END;
                end
                else
                    state_next = S_TOP;
            end
            S_TOP:
            begin
                if (!rd_reg[VALUE_WIDTH])
                begin
                    wr_en      = 1'b1;
                    wr_data    = {rd_reg[FW-1:FW-2], 1'b1, opnd_reg};
                    state_next = S_END;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    if (rsp.div_zero)
                    begin
                        sticky_next = pee_pkg::ST_NOVALUE;
                        state_next  = S_END;
                    end
                    else
                    begin
                        opnd_next  = alu_res;
                        sp_next    = sp_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_END:
            begin
                if (last_reg)
                begin
                    if (sticky_reg != pee_pkg::ST_OK)
                    begin
                        value_next  = '0;
                        status_next = sticky_reg;
                    end
                    else if (complete_reg)
                    begin
                        value_next  = 32'(final_reg);
                        status_next = pee_pkg::ST_OK;
                    end
                    else
                    begin
                        value_next  = '0;
                        status_next = pee_pkg::ST_NOVALUE;
                    end
                    sp_next       = '0;
                    complete_next = 1'b0;
                    sticky_next   = pee_pkg::ST_OK;
                    final_next    = '0;
                    state_next    = S_OUT;
                end
                else
                    state_next = S_IDLE;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            complete_reg <= 1'b0;
            sticky_reg   <= pee_pkg::ST_OK;
            final_reg    <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            complete_reg <= complete_next;
            sticky_reg   <= sticky_next;
            final_reg    <= final_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg   <= opnd_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Frame memory with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
        rd_reg <= frame_mem[rd_addr];
    end

endmodule

// ===== sv/pee_checker.sv =====
// ----------------------------------------------------------------------------
// Prefix expression evaluator port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module pee_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value,
    input logic [1:0]  status
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("result beat changed under stall");

    // An error status never carries a value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pee_pkg::ST_OK |-> value == 32'd0)
        else $error("error result with nonzero value");

    // The block never accepts a character while a result waits.
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // Acceptance of a character always stalls the input next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a beat");

endmodule

bind prefix_expression_evaluator pee_props u_pee_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);

// ===== dv/pee_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix expression evaluator checker
// Watches the character and result channels, evaluates each expression with
// its own frame-stack model and compares every result beat, field by field.
// ----------------------------------------------------------------------------
module pee_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  symbol,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] value,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } result_t;

    // Evaluator state.
    logic [1:0]  op_stack [STACK_DEPTH];
    logic        left_full [STACK_DEPTH];
    logic [31:0] left_val [STACK_DEPTH];
    int          depth;
    logic        done_expr;
    logic [31:0] done_value;
    logic [1:0]  err_code;
    int          fails = 0;

    result_t results_due[$];

    assign pending_count = results_due.size();
    assign fail_count    = fails;

    task automatic report(input string what);
        $display("pee_checker: %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == pee_pkg::CH_SPACE || (c >= pee_pkg::CH_TAB && c <= pee_pkg::CH_CR);
    endfunction

    // Signed division truncating toward zero; the most negative value
    // divided by -1 wraps to itself.
    function automatic logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    task automatic clear_expr();
        depth = 0;
        done_expr = 1'b0;
        done_value = '0;
        err_code = pee_pkg::ST_OK;
    endtask

    // A finished operand fills or collapses frames from the top down.
    task automatic fold_operand(input logic [31:0] v);
        int t;
        logic [31:0] l;
        while (depth > 0)
        begin
            t = depth - 1;
            if (!left_full[t])
            begin
                left_full[t] = 1'b1;
                left_val[t] = v;
                return;
            end
            l = left_val[t];
            case (op_stack[t])
                pee_pkg::OP_ADD: v = l + v;
                pee_pkg::OP_SUB: v = l - v;
                pee_pkg::OP_MUL: v = l * v;
                default:
                begin
                    if (v == 0)
                    begin
                        err_code = pee_pkg::ST_NOVALUE;
                        return;
                    end
                    v = quotient(l, v);
                end
            endcase
            depth = t;
        end
        done_expr = 1'b1;
        done_value = v;
    endtask

    task automatic take_symbol(input logic [7:0] c, input logic fin);
        result_t r;
        if (!done_expr && err_code == pee_pkg::ST_OK && !is_blank(c))
        begin
            if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE)
            begin
                fold_operand(32'(c - pee_pkg::CH_ZERO));
            end
            else if (c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS ||
                     c == pee_pkg::CH_STAR || c == pee_pkg::CH_SLASH)
            begin
                if (depth >= STACK_DEPTH)
                begin
                    err_code = pee_pkg::ST_OVERFLOW;
                end
                else
                begin
                    op_stack[depth] = c == pee_pkg::CH_PLUS  ? pee_pkg::OP_ADD
                                    : c == pee_pkg::CH_MINUS ? pee_pkg::OP_SUB
                                    : c == pee_pkg::CH_STAR  ? pee_pkg::OP_MUL
                                    : pee_pkg::OP_DIV;
                    left_full[depth] = 1'b0;
                    left_val[depth] = '0;
                    depth++;
                end
            end
            else
            begin
                err_code = pee_pkg::ST_BADCHAR;
            end
        end
        if (fin)
        begin
            if (err_code != pee_pkg::ST_OK)
            begin
                r = '{value: '0, status: err_code};
            end
            else if (done_expr)
            begin
                r = '{value: done_value, status: pee_pkg::ST_OK};
            end
            else
            begin
                r = '{value: '0, status: pee_pkg::ST_NOVALUE};
            end
            results_due.push_back(r);
            clear_expr();
        end
    endtask

    // Accepted beats on both channels.
    always @(posedge clk)
    begin
        result_t e;
        if (!rst_n)
        begin
            clear_expr();
            results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    report($sformatf("unexpected result value=%0h status=%0d", value, status));
                end
                else
                begin
                    e = results_due.pop_front();
                    if (status !== e.status)
                        report($sformatf("status %0d, want %0d", status, e.status));
                    if (value !== e.value)
                        report($sformatf("value %0h, want %0h", value, e.value));
                end
            end
            if (in_valid && !in_stall)
                take_symbol(symbol, last);
        end
    end

endmodule

// ===== dv/tb_prefix_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix expression evaluator testbench
// Sends directed and random prefix expressions in bursts against a stalling
// receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_prefix_expression_evaluator;

    localparam int STACK_DEPTH = 32;
    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  symbol;
    logic        last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] value;
    logic [1:0]  status;
    int          fail_count;
    int          pending_count;
    int          cycles = 0;
    int          burst_left;
    int          stall_mode = 0;
    byte         expr_text[$];

    prefix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(32)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
    );

    pee_checker #(.STACK_DEPTH(STACK_DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("prefix_expression_evaluator: mismatch");
            $finish;
        end
    end

    // Receiver stall pattern: changes mode now and then.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // One character beat; burst gaps fall before it.
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        symbol <= c;
        last <= fin;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_text.size(); i++)
            send_char(expr_text[i], i == expr_text.size() - 1);
        expr_text.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            expr_text.push_back(s[i]);
    endtask

    function automatic byte any_op();
        case ($urandom_range(0, 3))
            0: return pee_pkg::CH_PLUS;
            1: return pee_pkg::CH_MINUS;
            2: return pee_pkg::CH_STAR;
            default: return pee_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic byte any_blank();
        byte blanks[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        return blanks[$urandom_range(0, 5)];
    endfunction

    // Well-formed prefix expression with random operators and digits.
    task automatic build_tree(input int level);
        if ($urandom_range(0, 4) == 0)
            expr_text.push_back(any_blank());
        if (level == 0 || $urandom_range(0, 2) == 0)
        begin
            expr_text.push_back(8'(pee_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        else
        begin
            expr_text.push_back(any_op());
            build_tree(level - 1);
            build_tree(level - 1);
        end
    endtask

    initial
    begin
        string directed[$];
        int kind;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        symbol = '0;
        last = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operator, blanks, trailing and bad characters,
        // divide by zero, truncation, incomplete and empty input.
        directed = '{"+ 3 4", "- 2 9", "* 9 9", "/ 7 2", "/ - 0 7 2", "/ 5 0",
                     "+ 1", "5 x", "+ a 1", "\t+\n1\r2", "* * * 9 9 9 9",
                     "3", "0", "9", " ", "+ 1 2 3", "/ - 0 9 / 9 9"};
        foreach (directed[i])
        begin
            add_text(directed[i]);
            send_expr();
        end
        // Large values: 9^12 wraps; -8 times 8^10 wraps to zero, then is divided by -1.
        add_text("*********** 9 9 9 9 9 9 9 9 9 9 9 9");
        send_expr();
        add_text("/ * - 0 8 * * * * * * * * * 8 8 8 8 8 8 8 8 8 8 - 0 1");
        send_expr();
        // Stack full exactly, then overflow.
        repeat (STACK_DEPTH) expr_text.push_back(pee_pkg::CH_PLUS);
        repeat (STACK_DEPTH + 1) expr_text.push_back(8'd49);
        send_expr();
        repeat (STACK_DEPTH + 1) expr_text.push_back(pee_pkg::CH_MINUS);
        expr_text.push_back(8'd49);
        send_expr();
        // Every byte value once.
        for (int b = 0; b < 256; b++)
            send_char(8'(b), 1'b1);

        // Random expressions until about 650 more characters went in.
        for (int n = 0; n < 650; n += expr_text.size())
        begin
            kind = $urandom_range(0, 19);
            if (kind < 15)
            begin
                build_tree($urandom_range(1, 5));
                if (kind == 0)
                    expr_text.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind < 17)
            begin
                build_tree($urandom_range(1, 4));
                void'(expr_text.pop_back());
            end
            else
            begin
                repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(0, 255)));
            end
            n += expr_text.size();
            send_expr();
        end
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("prefix_expression_evaluator: match");
        else
            $display("prefix_expression_evaluator: mismatch");
        $finish;
    end

endmodule

// ===== prefix_expression_evaluator.f =====
sv/pee_pkg.sv
sv/pee_alu.sv
sv/prefix_expression_evaluator.sv
sv/pee_checker.sv
dv/pee_checker.sv
dv/tb_prefix_expression_evaluator.sv
